// ===== src/imufd_pkg.sv =====
// ----------------------------------------------------------------------------
// imufd_pkg: shared types and constants of the imu frame decoder
// frame byte codes, result kinds, fixed-point scaling constants and the
// records passed between the parser and the scaling stage
// ----------------------------------------------------------------------------
package imufd_pkg;

  // frame layout
  localparam logic [7:0] HDR_BYTE      = 8'h55;
  localparam logic [7:0] TYPE_ACCEL    = 8'h51;
  localparam logic [7:0] TYPE_GYRO     = 8'h52;
  localparam logic [7:0] TYPE_ANGLE    = 8'h53;
  localparam logic [3:0] POS_HDR       = 4'd0;
  localparam logic [3:0] POS_TYPE      = 4'd1;
  localparam logic [3:0] POS_FIRST_DAT = 4'd2;
  localparam logic [3:0] POS_LAST_DAT  = 4'd9;
  localparam int unsigned PAYLOAD_LEN  = 8;

  localparam int unsigned DEF_FRAMES_PER_BURST = 3;

  // result kinds
  localparam logic [1:0] KIND_ACCEL = 2'd0;
  localparam logic [1:0] KIND_GYRO  = 2'd1;
  localparam logic [1:0] KIND_ANGLE = 2'd2;

  // field widths
  localparam int unsigned AXIS_W = 20;
  localparam int unsigned TEMP_W = 17;

  // temperature: floor(raw*64/85) + 9280 done as an unsigned reciprocal multiply
  // on (raw + 32768)*64 + 53, then a fixed offset
  localparam logic [21:0] TEMP_BIAS   = 22'd53;
  localparam logic [22:0] TEMP_RECIP  = 23'd6316129;   // ceil(2^29 / 85)
  localparam int unsigned TEMP_SHIFT  = 29;
  localparam logic signed [16:0] TEMP_OFFSET = 17'sd15393;

  // raw frame words handed from the parser to the scaler
  typedef struct packed {
    logic [1:0]         kind;
    logic signed [15:0] word_x;
    logic signed [15:0] word_y;
    logic signed [15:0] word_z;
    logic signed [15:0] word_t;
  } raw_frame_t;

  // one scaled result item
  typedef struct packed {
    logic [1:0]                kind;
    logic signed [AXIS_W-1:0]  axis_x;
    logic signed [AXIS_W-1:0]  axis_y;
    logic signed [AXIS_W-1:0]  axis_z;
    logic signed [TEMP_W-1:0]  temperature;
  } result_t;

  function automatic logic type_known(input logic [7:0] t);
    type_known = (t == TYPE_ACCEL) || (t == TYPE_GYRO) || (t == TYPE_ANGLE);
  endfunction

endpackage

// ===== src/imufd_scale.sv =====
// ----------------------------------------------------------------------------
// imufd_scale: fixed-point scaling of one raw frame
// turns the four signed words of a frame into x, y, z and temperature with
// 8 fractional bits, rounded toward minus infinity
// ----------------------------------------------------------------------------
module imufd_scale
  import imufd_pkg::*;
(
  input  raw_frame_t raw_i,
  output result_t    res_o
);

  logic signed [AXIS_W-1:0] x_s, y_s, z_s;
  logic [15:0]              t_bias;
  logic [21:0]              t_num;
  logic [44:0]              t_prod;
  logic [15:0]              t_quot;

  function automatic logic signed [AXIS_W-1:0] scale_axis(input logic [1:0] kind,
                                                           input logic signed [15:0] r);
    logic signed [AXIS_W-1:0] acc_v;
    logic signed [22:0]       gyro_p;
    logic signed [21:0]       ang_p;
    acc_v  = AXIS_W'(r) >>> 3;
    gyro_p = 23'(r) * 23'sd125;
    ang_p  = 22'(r) * 22'sd45;
    case (kind)
      KIND_ACCEL: scale_axis = acc_v;
      KIND_GYRO:  scale_axis = gyro_p[22:3];
      default:    scale_axis = AXIS_W'($signed(ang_p[21:5]));
    endcase
  endfunction

  assign x_s = scale_axis(raw_i.kind, raw_i.word_x);
  assign y_s = scale_axis(raw_i.kind, raw_i.word_y);
  assign z_s = scale_axis(raw_i.kind, raw_i.word_z);

  // offset binary keeps the divide-by-85 unsigned
  assign t_bias = {~raw_i.word_t[15], raw_i.word_t[14:0]};
  assign t_num  = {t_bias, 6'b0} + TEMP_BIAS;
  assign t_prod = 45'(t_num) * 45'(TEMP_RECIP);
  assign t_quot = t_prod[TEMP_SHIFT +: 16];

  always_comb begin
    res_o.kind        = raw_i.kind;
    res_o.axis_x      = x_s;
    res_o.axis_y      = y_s;
    res_o.axis_z      = z_s;
    res_o.temperature = $signed({1'b0, t_quot}) - TEMP_OFFSET;
  end

endmodule

// ===== src/imu_frame_decoder_top.sv =====
// ----------------------------------------------------------------------------
// imu_frame_decoder_top: 11-byte imu serial frame parser
// parses received uart bytes into acceleration, angular rate and angle items
// ----------------------------------------------------------------------------
// The block takes one item per clock while ready: a received byte (tuser low) or an
// idle-line marker (tuser high) that ends a burst. Each burst holds up to
// FRAMES_PER_BURST frames of header 0x55, type byte (0x51 accel, 0x52 gyro,
// 0x53 angle), four little-endian signed words and an unchecked checksum. A
// result item is formed when the last payload byte (position 9) is accepted; it
// is held in the parser register and goes through the scaling stage into the
// output queue; an idle marker that cuts a known frame short gives
// the same item with the missing bytes read as zero, and then clears all
// parser state. A wrong header stops the burst until idle; an unknown type
// frame is consumed without a result. Input and output are parted by a
// two-entry output queue, so bytes are taken every cycle while the consumer
// keeps up; tready drops once two results are held between the scaler
// register and the queue.
// ----------------------------------------------------------------------------
module imu_frame_decoder_top
  import imufd_pkg::*;
#(
  parameter int unsigned FRAMES_PER_BURST = DEF_FRAMES_PER_BURST
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input stream
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] rx_byte
  input  logic        s_axis_tuser_i,   // [0] req_type (1 = line idle)
  // result stream
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [79:0] m_axis_tdata_o,   // [19:0] axis_x, [39:20] axis_y,
                                        // [59:40] axis_z, [76:60] temperature
  output logic [1:0]  m_axis_tuser_o    // [1:0] frame_kind
);

  localparam int unsigned FdW = $clog2(FRAMES_PER_BURST + 1);

  // parser state
  logic [3:0]     pos_q, pos_d;
  logic [FdW-1:0] frames_q, frames_d;
  logic           stopped_q, stopped_d;
  logic [7:0]     type_q, type_d;
  logic [7:0]     payload_q [PAYLOAD_LEN];
  logic [7:0]     payload_d [PAYLOAD_LEN];
  logic [7:0]     payload_upd [PAYLOAD_LEN];

  // parser to scaler register
  logic       raw_vld_q;
  raw_frame_t raw_q, raw_d;
  logic       emit;
  result_t    res_s;

  // output queue
  result_t    head_q, tail_q;
  logic [1:0] occ_q;
  logic       in_acc, out_pop;
  logic       active, data_pos;

  assign in_acc  = s_axis_tvalid_i && s_axis_tready_o;
  assign out_pop = m_axis_tvalid_o && m_axis_tready_i;

  // room for one more result counting the one in the scaler register
  assign s_axis_tready_o = (2'(occ_q) + 2'(raw_vld_q)) <= 2'd1;

  assign active   = !stopped_q && (frames_q < FdW'(FRAMES_PER_BURST));
  assign data_pos = (pos_q >= POS_FIRST_DAT) && (pos_q <= POS_LAST_DAT);

  // payload with the current data byte written in, used for the words of a result
  always_comb begin
    for (int i = 0; i < PAYLOAD_LEN; i++) begin
      payload_upd[i] = payload_q[i];
    end
    if (!s_axis_tuser_i && active && data_pos) begin
      payload_upd[3'(pos_q - POS_FIRST_DAT)] = s_axis_tdata_i;
    end
  end

  always_comb begin
    pos_d     = pos_q;
    frames_d  = frames_q;
    stopped_d = stopped_q;
    type_d    = type_q;
    for (int i = 0; i < PAYLOAD_LEN; i++) begin
      payload_d[i] = payload_q[i];
    end
    emit = 1'b0;
    if (in_acc) begin
      if (s_axis_tuser_i) begin
        // line idle: flush a cut-short known frame, then back to reset state
        emit      = active && data_pos && type_known(type_q);
        pos_d     = POS_HDR;
        frames_d  = '0;
        stopped_d = 1'b0;
        type_d    = '0;
        for (int i = 0; i < PAYLOAD_LEN; i++) begin
          payload_d[i] = '0;
        end
      end else if (active) begin
        if (pos_q == POS_HDR) begin
          if (s_axis_tdata_i != HDR_BYTE) begin
            stopped_d = 1'b1;
          end else begin
            type_d = '0;
            for (int i = 0; i < PAYLOAD_LEN; i++) begin
              payload_d[i] = '0;
            end
            pos_d = POS_TYPE;
          end
        end else if (pos_q == POS_TYPE) begin
          type_d = s_axis_tdata_i;
          pos_d  = POS_FIRST_DAT;
        end else if (data_pos) begin
          for (int i = 0; i < PAYLOAD_LEN; i++) begin
            payload_d[i] = payload_upd[i];
          end
          emit  = (pos_q == POS_LAST_DAT) && type_known(type_q);
          pos_d = pos_q + 4'd1;
        end else begin
          // checksum byte closes the frame
          pos_d    = POS_HDR;
          frames_d = frames_q + FdW'(1);
        end
      end
    end
  end

  always_comb begin
    raw_d.kind   = 2'(type_q - TYPE_ACCEL);
    raw_d.word_x = {payload_upd[1], payload_upd[0]};
    raw_d.word_y = {payload_upd[3], payload_upd[2]};
    raw_d.word_z = {payload_upd[5], payload_upd[4]};
    raw_d.word_t = {payload_upd[7], payload_upd[6]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= POS_HDR;
      frames_q  <= '0;
      stopped_q <= 1'b0;
      type_q    <= '0;
      for (int i = 0; i < PAYLOAD_LEN; i++) begin
        payload_q[i] <= '0;
      end
      raw_vld_q <= 1'b0;
    end else begin
      pos_q     <= pos_d;
      frames_q  <= frames_d;
      stopped_q <= stopped_d;
      type_q    <= type_d;
      for (int i = 0; i < PAYLOAD_LEN; i++) begin
        payload_q[i] <= payload_d[i];
      end
      raw_vld_q <= emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      raw_q <= raw_d;
    end
  end

  imufd_scale u_scale (
    .raw_i (raw_q),
    .res_o (res_s)
  );

  // two-entry output queue: head is shown on the port
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= 2'd0;
    end else begin
      occ_q <= occ_q + 2'(raw_vld_q) - 2'(out_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (raw_vld_q && ((occ_q == 2'd0) || ((occ_q == 2'd1) && out_pop))) begin
      head_q <= res_s;
    end else if (out_pop) begin
      head_q <= tail_q;
    end
    if (raw_vld_q && (occ_q != 2'd0) && !((occ_q == 2'd1) && out_pop)) begin
      tail_q <= res_s;
    end
  end

  assign m_axis_tvalid_o = occ_q != 2'd0;
  assign m_axis_tuser_o  = head_q.kind;
  assign m_axis_tdata_o  = {3'b000, head_q.temperature, head_q.axis_z,
                            head_q.axis_y, head_q.axis_x};

endmodule

// ===== src/imufd_checker.sv =====
// ----------------------------------------------------------------------------
// imufd_checker: port-level checks of the imu frame decoder
// watches both streams of the top level and is bound to it
// ----------------------------------------------------------------------------
module imufd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [79:0] m_axis_tdata_o,
  input logic [1:0]  m_axis_tuser_o
);

  // a waiting result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("result item dropped while stalled");

  // input back-pressure only while results are queued
  a_ready_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> m_axis_tvalid_o)
    else $error("input stalled with no result waiting");

  // a result appearing on an empty port comes from an earlier accepted item
  a_out_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> $past(s_axis_tvalid_i && s_axis_tready_o, 2))
    else $error("result item without a source item");

  // kind code three is never produced and the padding bits stay zero
  a_kind_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tuser_o != 2'd3) && (m_axis_tdata_o[79:77] == 3'b000))
    else $error("bad frame kind or padding on result item");

endmodule

bind imu_frame_decoder_top imufd_checker u_imufd_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);

// ===== tb/imu_frame_decoder_top_tb.sv =====
// ----------------------------------------------------------------------------
// imu_frame_decoder_top_tb: self-checking bench for the imu frame decoder
// byte and idle-line items go in through the input stream. A parser model
// inside the bench tracks each accepted item and queues the scaled frames it
// should produce. Every result item is checked field by field against the
// oldest queued frame. The sender inserts random gaps and the receiver stalls
// at random, with one long hold-off to fill the block up.
// ----------------------------------------------------------------------------
module imu_frame_decoder_top_tb;
  import imufd_pkg::*;

  localparam int unsigned FRAMES_PER_BURST = DEF_FRAMES_PER_BURST;
  localparam int          FRAME_LEN        = 11;
  localparam int          TEMP_BASE        = 9280;   // 36.25 degC in 8.8 fixed point
  localparam logic [7:0]  BAD_HDR          = 8'hAA;
  localparam logic [7:0]  UNUSED_TYPE      = 8'h54;
  localparam logic [8:0]  IDLE_MARK        = 9'h100;
  localparam int          LONG_HOLD        = 60;
  localparam int          STALL_LIMIT      = 1000;
  localparam int          RANDOM_ITEMS     = 1100;
  localparam int          STEADY_ITEMS     = 150;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [7:0]  s_axis_tdata_i = '0;   // [7:0] rx_byte
  logic        s_axis_tuser_i = 1'b0; // [0] req_type
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [79:0] m_axis_tdata_o;        // [19:0] x, [39:20] y, [59:40] z, [76:60] temperature
  logic [1:0]  m_axis_tuser_o;        // [1:0] frame_kind

  imu_frame_decoder_top #(
    .FRAMES_PER_BURST(FRAMES_PER_BURST)
  ) i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o)
  );

  always #5 clk_i = ~clk_i;

  // parser model state
  logic [3:0]  frame_pos;
  int          burst_frames;
  bit          burst_halted;
  logic [7:0]  frame_type;
  logic [63:0] frame_payload;   // frame bytes 2..9, byte 2 lowest

  result_t     scaled_frames_q [$];
  result_t     want_frame;
  int          taken_items;
  int          fails;
  int          quiet_cycles;
  bit          gaps_on;
  bit          stalls_on;
  bit          long_hold;

  function automatic int floor_div(input int num, input int den);
    int q;
    q = num / den;
    if ((num % den) != 0 && num < 0) q = q - 1;
    return q;
  endfunction

  // scale the current frame words into one result
  function automatic result_t scale_frame(input logic [7:0] type_b, input logic [63:0] words);
    result_t res;
    int      raw;
    int      axis [3];
    res.kind = 2'(type_b - TYPE_ACCEL);
    for (int k = 0; k < 3; k++) begin
      raw = int'($signed(words[k*16 +: 16]));
      case (res.kind)
        KIND_ACCEL: axis[k] = floor_div(raw, 8);
        KIND_GYRO:  axis[k] = floor_div(raw * 125, 8);
        default:    axis[k] = floor_div(raw * 45, 32);
      endcase
    end
    res.axis_x      = axis[0][AXIS_W-1:0];
    res.axis_y      = axis[1][AXIS_W-1:0];
    res.axis_z      = axis[2][AXIS_W-1:0];
    raw             = int'($signed(words[63:48]));
    raw             = floor_div(raw * 64, 85) + TEMP_BASE;
    res.temperature = raw[TEMP_W-1:0];
    return res;
  endfunction

  function automatic bit known_type(input logic [7:0] type_b);
    return type_b inside {TYPE_ACCEL, TYPE_GYRO, TYPE_ANGLE};
  endfunction

  task automatic clear_parser();
    frame_pos     = POS_HDR;
    burst_frames  = 0;
    burst_halted  = 1'b0;
    frame_type    = '0;
    frame_payload = '0;
  endtask

  // follow one accepted item through the parser and queue any result it causes
  task automatic track_parser(input bit idle_mark, input logic [7:0] data_b);
    bit live;
    live = !burst_halted && burst_frames < FRAMES_PER_BURST;
    taken_items++;
    if (idle_mark) begin
      // a known frame cut short by idle still leaves, missing bytes as zero
      if (live && frame_pos >= POS_FIRST_DAT && frame_pos <= POS_LAST_DAT &&
          known_type(frame_type))
        scaled_frames_q.push_back(scale_frame(frame_type, frame_payload));
      clear_parser();
    end else if (live) begin
      if (frame_pos == POS_HDR) begin
        if (data_b != HDR_BYTE) begin
          burst_halted = 1'b1;
        end else begin
          frame_type    = '0;
          frame_payload = '0;
          frame_pos     = POS_TYPE;
        end
      end else if (frame_pos == POS_TYPE) begin
        frame_type = data_b;
        frame_pos  = POS_FIRST_DAT;
      end else if (frame_pos <= POS_LAST_DAT) begin
        frame_payload[(frame_pos - POS_FIRST_DAT) * 8 +: 8] = data_b;
        if (frame_pos == POS_LAST_DAT && known_type(frame_type))
          scaled_frames_q.push_back(scale_frame(frame_type, frame_payload));
        frame_pos = frame_pos + 4'd1;
      end else begin
        // checksum byte just closes the frame
        frame_pos    = POS_HDR;
        burst_frames = burst_frames + 1;
      end
    end
  endtask

  // offer one item, hold it until taken, then update the model
  task automatic send_item(input bit idle_mark, input logic [7:0] data_b);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= data_b;
    s_axis_tuser_i  <= idle_mark;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    track_parser(idle_mark, data_b);
  endtask

  // payload bytes lean towards the word extremes
  function automatic logic [7:0] pick_payload_byte();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      2:       return 8'h7F;
      3:       return 8'h80;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // one frame, optionally with a broken header or cut short by idle at cut_at
  task automatic send_frame(input logic [7:0] type_b, input bit bad_hdr, input int cut_at,
                            output bit was_cut);
    logic [7:0] data_b;
    was_cut = 1'b0;
    for (int k = 0; k < FRAME_LEN; k++) begin
      if (k == cut_at) begin
        send_item(1'b1, 8'($urandom_range(0, 255)));
        was_cut = 1'b1;
        return;
      end
      if (k == 0)
        data_b = bad_hdr ? (HDR_BYTE ^ 8'($urandom_range(1, 255))) : HDR_BYTE;
      else if (k == 1)
        data_b = type_b;
      else
        data_b = pick_payload_byte();
      send_item(1'b0, data_b);
    end
  endtask

  task automatic send_random_burst();
    int         n_frames;
    int         cut_at;
    bit         was_cut;
    logic [7:0] type_b;
    // plain noise now and then
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 5)) send_item(1'b0, 8'($urandom_range(0, 255)));
      send_item(1'b1, 8'($urandom_range(0, 255)));
      return;
    end
    n_frames = $urandom_range(0, FRAMES_PER_BURST + 1);
    for (int f = 0; f < n_frames; f++) begin
      if ($urandom_range(0, 7) == 0)
        type_b = 8'($urandom_range(0, 255));
      else
        type_b = TYPE_ACCEL + 8'($urandom_range(0, 2));
      cut_at = ($urandom_range(0, 5) == 0) ? $urandom_range(0, FRAME_LEN - 1) : FRAME_LEN;
      send_frame(type_b, $urandom_range(0, 15) == 0, cut_at, was_cut);
      if (was_cut) return;
    end
    send_item(1'b1, 8'($urandom_range(0, 255)));
  endtask

  task automatic wait_results_drained();
    s_axis_tvalid_i <= 1'b0;
    while (scaled_frames_q.size() != 0) @(posedge clk_i);
  endtask

  // extremes of each kind, idle cut, unknown type and a broken header
  task automatic test_directed_frames();
    logic [8:0] seq [$];
    gaps_on   = 1'b1;
    stalls_on = 1'b1;
    seq = '{{1'b0, HDR_BYTE}, {1'b0, TYPE_ACCEL},
            9'h0FF, 9'h07F, 9'h000, 9'h080, 9'h0FF, 9'h0FF, 9'h000, 9'h080, 9'h03C,
            {1'b0, HDR_BYTE}, {1'b0, TYPE_GYRO}, 9'h000, 9'h080, IDLE_MARK,
            {1'b0, HDR_BYTE}, {1'b0, TYPE_ANGLE}, 9'h0FF, 9'h07F, IDLE_MARK | 9'h0A5,
            {1'b0, HDR_BYTE}, {1'b0, UNUSED_TYPE}, 9'h011, IDLE_MARK,
            {1'b0, BAD_HDR}, {1'b0, HDR_BYTE}, {1'b0, TYPE_ACCEL}, IDLE_MARK};
    foreach (seq[i]) send_item(seq[i][8], seq[i][7:0]);
  endtask

  task automatic test_random_bursts();
    while (taken_items < RANDOM_ITEMS) begin
      gaps_on   = ($urandom_range(0, 3) != 0);
      stalls_on = ($urandom_range(0, 3) != 0);
      send_random_burst();
    end
  endtask

  // receiver holds off while a full burst plus one spare frame streams in
  task automatic test_output_backpressure();
    bit was_cut;
    gaps_on   = 1'b0;
    long_hold = 1'b1;
    for (int f = 0; f <= FRAMES_PER_BURST; f++)
      send_frame(TYPE_ACCEL + 8'($urandom_range(0, 2)), 1'b0, FRAME_LEN, was_cut);
    send_item(1'b1, 8'($urandom_range(0, 255)));
    wait (!long_hold);
    wait_results_drained();
  endtask

  // sender stops until all results are out, then carries on
  task automatic test_drain_pause();
    gaps_on   = 1'b1;
    stalls_on = 1'b1;
    repeat (2) send_random_burst();
    wait_results_drained();
    repeat (2) send_random_burst();
  endtask

  // no idling on either side
  task automatic test_steady_stream();
    int stop_at;
    stop_at   = taken_items + STEADY_ITEMS;
    gaps_on   = 1'b0;
    stalls_on = 1'b0;
    while (taken_items < stop_at) send_random_burst();
  endtask

  initial begin
    clear_parser();
    taken_items = 0;
    fails       = 0;
    gaps_on     = 1'b0;
    stalls_on   = 1'b0;
    long_hold   = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_frames();
    test_output_backpressure();
    test_random_bursts();
    test_drain_pause();
    test_steady_stream();
    wait_results_drained();
    // catch any stray result after the last expected one
    repeat (8) @(posedge clk_i);
    if (fails == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // result receiver: random short stalls, one long hold-off on request
  initial begin
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (long_hold) begin
        m_axis_tready_i <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
        long_hold = 1'b0;
        m_axis_tready_i <= 1'b1;
      end else if (stalls_on && $urandom_range(0, 3) == 0) begin
        m_axis_tready_i <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk_i);
        m_axis_tready_i <= 1'b1;
      end else if (!m_axis_tready_i) begin
        m_axis_tready_i <= 1'b1;
      end
    end
  end

  task automatic report_field(input string field, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s expected %0d actual %0d", $time, field, want, got);
      fails++;
    end
  endtask

  // result checker
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (scaled_frames_q.size() == 0) begin
        $display("%0t: frame_kind expected none actual %0d", $time, m_axis_tuser_o);
        fails++;
      end else begin
        want_frame = scaled_frames_q.pop_front();
        report_field("frame_kind", int'(want_frame.kind), int'(m_axis_tuser_o));
        report_field("axis_x", int'(want_frame.axis_x), int'($signed(m_axis_tdata_o[19:0])));
        report_field("axis_y", int'(want_frame.axis_y), int'($signed(m_axis_tdata_o[39:20])));
        report_field("axis_z", int'(want_frame.axis_z), int'($signed(m_axis_tdata_o[59:40])));
        report_field("temperature", int'(want_frame.temperature),
                     int'($signed(m_axis_tdata_o[76:60])));
      end
    end
  end

  // watchdog on cycles with no item moving on either side
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i))
      quiet_cycles = 0;
    else
      quiet_cycles = quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

endmodule

// ===== sim.f =====
src/imufd_pkg.sv
src/imufd_scale.sv
src/imu_frame_decoder_top.sv
src/imufd_checker.sv
tb/imu_frame_decoder_top_tb.sv
